@@ hdl/samg_pkg.sv @@
// Shared types, widths and constants of the sprite alpha mask generator.
package samg_pkg;

    localparam int MAX_SIDE  = 1024;
    localparam int FRAC      = 4;
    localparam int SIDE_W    = 11;
    localparam int DELTA_W   = 13;
    localparam int SQ_W      = 23;
    localparam int SQV_W     = 32;
    localparam int ROOT_W    = SQV_W / 2;
    localparam int REM_W     = ROOT_W + 4;
    localparam int RAD_W     = SIDE_W + FRAC;
    localparam int NUM_W     = RAD_W + 8;
    localparam int RECIP_SH  = 20;
    localparam int RECIP_W   = 17;
    localparam int PROD_W    = ROOT_W + RECIP_W;
    localparam int E_W       = PROD_W - RECIP_SH;

    localparam int LIGHT_DIV = (160 << FRAC) / 256;
    localparam int CONE_DIV  = (400 << FRAC) / 256;
    localparam int LIGHT_M   = (1 << RECIP_SH) / LIGHT_DIV;
    localparam int CONE_M    = (1 << RECIP_SH) / CONE_DIV;

    localparam logic [2:0] SHAPE_CIRCLE = 3'd0;
    localparam logic [2:0] SHAPE_CROSS  = 3'd1;
    localparam logic [2:0] SHAPE_SOLID  = 3'd2;
    localparam logic [2:0] SHAPE_CONE   = 3'd3;
    localparam logic [2:0] SHAPE_LIGHT  = 3'd4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SHAPE  = 2'd2;
    localparam logic [1:0] REG_SOLID  = 2'd3;

    localparam logic [15:0] POW_TAB [8] = '{
        16'd46341, 16'd55109, 16'd60097, 16'd62757,
        16'd64132, 16'd64830, 16'd65182, 16'd65359
    };

    typedef struct packed {
        logic [SIDE_W-1:0] width;
        logic [SIDE_W-1:0] height;
        logic [2:0]        shape;
        logic [7:0]        solid;
    } cfg_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic                      cross_ok;
        logic                      wedge_clip;
        logic                      back_side;
    } fb_item_t;

endpackage

@@ hdl/sprite_alpha_mask_generator_top.sv @@
// Top level of the sprite alpha mask generator with its register port.
//   channel  direction  handshake                  payload
//   pixel    in         in_valid / in_stall        pixel_x, pixel_y
//   alpha    out        out_valid / out_stall      alpha_out
//   config   in         psel / penable / pwrite    paddr, pwdata, prdata
// One pixel beat is accepted per cycle while in_stall is low.
// The pipeline is one load stage, 16 root stages, two reciprocal stages,
// eight divide and power stages and the output register.
// Reset clears all control state at once; there is no clearing pass.
// A stalled output freezes the back end; the four-entry queue keeps accepting until full.
module sprite_alpha_mask_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [9:0]  pixel_x,
    input  logic [9:0]  pixel_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  alpha_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    samg_pkg::cfg_t cfg_reg;
    samg_pkg::fb_item_t item;
    samg_pkg::fb_item_t head;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic push;
    logic wr_en;
    logic [samg_pkg::SIDE_W-1:0] side_next;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;
    assign in_stall = q_full;
    assign push = in_valid && !q_full;
    assign side_next = (pwdata[10:0] > samg_pkg::SIDE_W'(samg_pkg::MAX_SIDE))
                       ? samg_pkg::SIDE_W'(samg_pkg::MAX_SIDE) : pwdata[10:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= samg_pkg::SIDE_W'(1);
            cfg_reg.height <= samg_pkg::SIDE_W'(1);
            cfg_reg.shape  <= samg_pkg::SHAPE_CIRCLE;
            cfg_reg.solid  <= 8'd255;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                samg_pkg::REG_WIDTH:  cfg_reg.width  <= side_next;
                samg_pkg::REG_HEIGHT: cfg_reg.height <= side_next;
                samg_pkg::REG_SHAPE:  cfg_reg.shape  <= pwdata[2:0];
                samg_pkg::REG_SOLID:  cfg_reg.solid  <= pwdata[7:0];
                default:              cfg_reg.solid  <= cfg_reg.solid;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            samg_pkg::REG_WIDTH:  prdata = 32'(cfg_reg.width);
            samg_pkg::REG_HEIGHT: prdata = 32'(cfg_reg.height);
            samg_pkg::REG_SHAPE:  prdata = 32'(cfg_reg.shape);
            samg_pkg::REG_SOLID:  prdata = 32'(cfg_reg.solid);
            default:              prdata = 32'd0;
        endcase
    end

    samg_front u_front (
        .cfg     (cfg_reg),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .item    (item)
    );

    samg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (item),
        .pop       (q_pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    samg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .alpha_out (alpha_out)
    );

endmodule

@@ hdl/samg_front.sv @@
// Front end: centre offsets and shape classification of each pixel beat.
module samg_front (
    input  samg_pkg::cfg_t   cfg,
    input  logic [9:0]       pixel_x,
    input  logic [9:0]       pixel_y,
    output samg_pkg::fb_item_t item
);

    logic signed [samg_pkg::DELTA_W-1:0] dx;
    logic signed [samg_pkg::DELTA_W-1:0] dy;
    logic signed [15:0] xi;
    logic signed [15:0] yi;
    logic signed [15:0] five_yi;
    logic col;
    logic row;

    always_comb
    begin
        dx = $signed({2'b00, pixel_x, 1'b0}) - $signed({2'b00, cfg.width});
        dy = $signed({2'b00, cfg.height}) - $signed({2'b00, pixel_y, 1'b0});
        xi = 16'(dx) / 16'sd2;
        yi = (-16'(dy)) / 16'sd2;
        five_yi = (yi <<< 2) + yi;
        col = (dy > -13'sd6) && (dy < 13'sd6);
        row = (dx > -13'sd6) && (dx < 13'sd6);
        item.dx = dx;
        item.dy = dy;
        item.cross_ok = col ^ row;
        item.wedge_clip = (xi > 16'sd0)
                          && ((five_yi > xi + 16'sd60) || (five_yi < -xi - 16'sd60));
        item.back_side = (xi <= 16'sd0);
    end

endmodule

@@ hdl/samg_queue.sv @@
// Four-entry queue between the front end and the arithmetic back end.
module samg_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  samg_pkg::fb_item_t push_data,
    input  logic               pop,
    output samg_pkg::fb_item_t head,
    output logic               full,
    output logic               empty
);

    localparam int DEPTH = 4;

    samg_pkg::fb_item_t mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    assign full  = (count_reg == 3'(DEPTH));
    assign empty = (count_reg == 3'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 3'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(DEPTH)) else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> !full) else $error("push into full queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 3'd1))
        else $error("queue count did not advance");
`endif

endmodule

@@ hdl/samg_back.sv @@
// Back end: pipelined root, falloff divide and power-of-two falloff.
module samg_back (
    input  logic               clk,
    input  logic               rst_n,
    input  samg_pkg::cfg_t     cfg,
    input  logic               q_empty,
    input  samg_pkg::fb_item_t q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         alpha_out
);

    localparam int SQRT_N = samg_pkg::ROOT_W;
    localparam int PREP   = SQRT_N + 1;
    localparam int STEP0  = PREP + 2;
    localparam int NSTG   = STEP0 + 8;

    typedef struct packed {
        logic [samg_pkg::SQ_W-1:0]   sq;
        logic [samg_pkg::REM_W-1:0]  rem;
        logic [samg_pkg::ROOT_W-1:0] root;
        logic                        cross_ok;
        logic                        wedge_clip;
        logic                        back_side;
        logic                        inr;
        logic [samg_pkg::NUM_W-1:0]  num;
        logic [7:0]                  quo;
        logic [samg_pkg::PROD_W-1:0] prod;
        logic [samg_pkg::E_W-1:0]    e;
        logic [16:0]                 m;
    } bk_t;

    bk_t pipe_reg [NSTG];
    logic [NSTG-1:0] vld_reg;
    logic out_valid_reg;
    logic [7:0] alpha_reg;
    logic en;
    logic cone;
    logic [samg_pkg::SIDE_W-1:0] min_side;
    logic [samg_pkg::RAD_W-1:0] rad;
    logic [samg_pkg::SQV_W-1:0] sqv [SQRT_N];

    function automatic bk_t load_fn(samg_pkg::fb_item_t it);
        bk_t o;
        logic signed [2*samg_pkg::DELTA_W-1:0] px2;
        logic signed [2*samg_pkg::DELTA_W-1:0] py2;
        o = '0;
        px2 = it.dx * it.dx;
        py2 = it.dy * it.dy;
        o.sq = samg_pkg::SQ_W'(px2) + samg_pkg::SQ_W'(py2);
        o.cross_ok = it.cross_ok;
        o.wedge_clip = it.wedge_clip;
        o.back_side = it.back_side;
        return o;
    endfunction

    function automatic bk_t sqrt_fn(bk_t s, logic [1:0] b);
        bk_t o;
        logic [samg_pkg::REM_W-1:0] acc;
        logic [samg_pkg::REM_W-1:0] trial;
        o = s;
        acc = {s.rem[samg_pkg::REM_W-3:0], b};
        trial = {2'b00, s.root, 2'b01};
        if (acc >= trial)
        begin
            o.rem = acc - trial;
            o.root = {s.root[samg_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = acc;
            o.root = {s.root[samg_pkg::ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic bk_t prep_fn(bk_t s, logic [samg_pkg::RAD_W-1:0] r_lim, logic is_cone);
        bk_t o;
        logic [samg_pkg::RAD_W-1:0] diff;
        logic [samg_pkg::RECIP_W-1:0] recip;
        o = s;
        o.inr = (s.root <= samg_pkg::ROOT_W'(r_lim));
        diff = r_lim - samg_pkg::RAD_W'(s.root);
        if (o.inr && (r_lim != '0))
        begin
            o.num = {diff, 8'd0} - samg_pkg::NUM_W'(diff);
        end
        else
        begin
            o.num = '0;
        end
        recip = is_cone ? samg_pkg::RECIP_W'(samg_pkg::CONE_M)
                        : samg_pkg::RECIP_W'(samg_pkg::LIGHT_M);
        o.prod = samg_pkg::PROD_W'(s.root) * samg_pkg::PROD_W'(recip);
        return o;
    endfunction

    function automatic bk_t corr_fn(bk_t s, logic is_cone);
        bk_t o;
        logic [samg_pkg::E_W-1:0] q0;
        logic [samg_pkg::ROOT_W:0] dv;
        logic [samg_pkg::ROOT_W:0] chk;
        o = s;
        q0 = s.prod[samg_pkg::PROD_W-1:samg_pkg::RECIP_SH];
        dv = is_cone ? (samg_pkg::ROOT_W+1)'(samg_pkg::CONE_DIV)
                     : (samg_pkg::ROOT_W+1)'(samg_pkg::LIGHT_DIV);
        chk = {1'b0, s.root} - (samg_pkg::ROOT_W+1)'(q0 * dv);
        o.e = (chk >= dv) ? q0 + samg_pkg::E_W'(1) : q0;
        o.m = 17'h10000;
        o.quo = '0;
        return o;
    endfunction

    function automatic bk_t step_fn(bk_t s, logic [samg_pkg::RAD_W-1:0] r_lim, int k);
        bk_t o;
        logic [samg_pkg::NUM_W-1:0] dv;
        logic [32:0] mm;
        o = s;
        dv = samg_pkg::NUM_W'(r_lim) << (7 - k);
        if ((r_lim != '0) && (s.num >= dv))
        begin
            o.num = s.num - dv;
            o.quo[7-k] = 1'b1;
        end
        mm = 33'(s.m) * 33'(samg_pkg::POW_TAB[k]);
        if (s.e[7-k])
        begin
            o.m = mm[32:16];
        end
        return o;
    endfunction

    function automatic logic [7:0] final_fn(bk_t s, samg_pkg::cfg_t c);
        logic [4:0] ip;
        logic [16:0] ms;
        logic [24:0] p;
        logic [7:0] pw;
        logic [7:0] a;
        ip = s.e[samg_pkg::E_W-1:8];
        ms = (ip >= 5'd17) ? 17'd0 : (s.m >> ip);
        p = {ms, 8'd0} - 25'(ms);
        pw = s.inr ? p[23:16] : 8'd0;
        case (c.shape)
            samg_pkg::SHAPE_CIRCLE: a = s.quo;
            samg_pkg::SHAPE_CROSS:  a = s.cross_ok ? s.quo : 8'd0;
            samg_pkg::SHAPE_SOLID:  a = c.solid;
            samg_pkg::SHAPE_CONE:
            begin
                if (s.wedge_clip || (s.back_side && (s.sq > samg_pkg::SQ_W'(576))))
                begin
                    a = 8'd0;
                end
                else
                begin
                    a = pw;
                end
            end
            samg_pkg::SHAPE_LIGHT:  a = pw;
            default:                a = 8'd0;
        endcase
        return a;
    endfunction

    assign en = !(out_valid_reg && out_stall);
    assign q_pop = en && !q_empty;
    assign cone = (cfg.shape == samg_pkg::SHAPE_CONE);
    assign min_side = (cfg.width < cfg.height) ? cfg.width : cfg.height;
    assign rad = {min_side, samg_pkg::FRAC'(0)};
    assign out_valid = out_valid_reg;
    assign alpha_out = alpha_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= load_fn(q_head);
            pipe_reg[PREP] <= prep_fn(pipe_reg[SQRT_N], rad, cone);
            pipe_reg[PREP+1] <= corr_fn(pipe_reg[PREP], cone);
            alpha_reg <= final_fn(pipe_reg[NSTG-1], cfg);
        end
    end

    for (genvar i = 0; i < SQRT_N; i++)
    begin : g_sqrt
        assign sqv[i] = {1'b0, pipe_reg[i].sq, (2*samg_pkg::FRAC)'(0)};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pipe_reg[i+1] <= sqrt_fn(pipe_reg[i], sqv[i][samg_pkg::SQV_W-1-2*i -: 2]);
            end
        end
    end

    for (genvar k = 0; k < 8; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pipe_reg[STEP0+k] <= step_fn(pipe_reg[STEP0+k-1], rad, k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], q_pop};
            out_valid_reg <= vld_reg[NSTG-1];
        end
    end

endmodule
